// File: design/ctd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the capture trace deframer.
// Depends on nothing; every other design file refers to it by scoped names.
package ctd_pkg;

   localparam int TRACE_W   = 64;
   localparam int LEN_W     = 11;
   localparam int CYC_W     = 28;
   localparam int SEC_W     = 32;
   localparam int NS_W      = 30;
   localparam int VB_W      = 4;
   localparam int KIND_W    = 2;

   localparam int LEN_LSB   = 53;
   localparam int CYC_LSB   = 25;

   localparam logic [TRACE_W-1:0] END_MARK = {TRACE_W{1'b1}};
   localparam logic [LEN_W-1:0]   MAX_CAP_RESET = {LEN_W{1'b1}};

   // Division of twice the cycle count by five: multiply by the reciprocal.
   localparam int RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_5 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 34;
   localparam int PROD_W      = CYC_W + 1 + RECIP_W;
   localparam int FIFTH_W     = PROD_W - RECIP_SHIFT;
   localparam int SIX_W       = 31;
   localparam int DELTA_W     = 32;

   localparam logic [DELTA_W-1:0] NS_PER_SEC     = 32'd1_000_000_000;
   localparam logic [DELTA_W-1:0] NS_PER_TWO_SEC = 32'd2_000_000_000;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_META = 2'd0,
      PH_DATA = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   // One classified item as it travels from the front end to the back end.
   typedef struct packed {
      kind_type             kind;
      logic [LEN_W-1:0]     capture_length;
      logic [LEN_W-1:0]     wire_length;
      logic [SIX_W-1:0]     six_cycles;
      logic [FIFTH_W-1:0]   fifth_cycles;
      logic [TRACE_W-1:0]   data_word;
      logic [VB_W-1:0]      valid_bytes;
      logic                 last;
   } entry_type;

endpackage

// File: design/ctd_fifo.sv
`timescale 1ns / 1ps
// Short register queue of classified items between front and back end.
// Depends on ctd_pkg for the entry type and default depth.
module ctd_fifo #(
   parameter int Depth = ctd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ctd_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output ctd_pkg::entry_type  pop_entry,
   output logic                empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   ctd_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign empty     = (count_ff == '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

// File: design/ctd_front.sv
`timescale 1ns / 1ps
// Front end: takes trace words, tracks packet framing and classifies each word.
// Depends on ctd_pkg; feeds ctd_fifo.
module ctd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ctd_pkg::TRACE_W-1:0]   req_trace_word,
   input  logic                          csr_write_enable,
   input  logic [ctd_pkg::LEN_W-1:0]     csr_write_data,
   input  logic                          queue_full,
   output logic                          queue_push,
   output ctd_pkg::entry_type            queue_entry
);

   ctd_pkg::phase_type phase_ff, phase_in;
   logic [ctd_pkg::LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic                      packet_seen_ff, packet_seen_in;
   logic [ctd_pkg::LEN_W-1:0] max_cap_ff;

   logic                          accept;
   logic                          is_end;
   logic [ctd_pkg::LEN_W-1:0]     wire_len;
   logic [ctd_pkg::LEN_W-1:0]     cap_len;
   logic [ctd_pkg::CYC_W-1:0]     cyc_used;
   logic [ctd_pkg::PROD_W-1:0]    prod;
   logic [ctd_pkg::SIX_W-1:0]     six;
   logic [ctd_pkg::VB_W-1:0]      take;
   logic                          last_word;

   function automatic logic [ctd_pkg::TRACE_W-1:0] keep_mask(input logic [ctd_pkg::VB_W-1:0] n);
      logic [ctd_pkg::TRACE_W-1:0] m;
      m = '0;
      for (int i = 0; i < ctd_pkg::TRACE_W / 8; i++) begin
         m[8*i +: 8] = (ctd_pkg::VB_W'(i) < n) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   assign req_ready = (phase_ff == ctd_pkg::PH_DONE) || !queue_full;
   assign accept    = req_valid && req_ready;

   assign is_end   = (req_trace_word == ctd_pkg::END_MARK);
   assign wire_len = req_trace_word[ctd_pkg::LEN_LSB +: ctd_pkg::LEN_W];
   assign cap_len  = (wire_len > max_cap_ff) ? max_cap_ff : wire_len;
   // The first packet has no predecessor, so its gap counts as zero.
   assign cyc_used = packet_seen_ff ? req_trace_word[ctd_pkg::CYC_LSB +: ctd_pkg::CYC_W] : '0;
   // floor(32c/5) = 6c + floor(2c/5)
   assign prod     = ctd_pkg::PROD_W'({cyc_used, 1'b0}) * ctd_pkg::PROD_W'(ctd_pkg::RECIP_5);
   assign six      = (ctd_pkg::SIX_W'(cyc_used) << 2) + (ctd_pkg::SIX_W'(cyc_used) << 1);

   assign take      = (bytes_left_ff > ctd_pkg::LEN_W'(8)) ? ctd_pkg::VB_W'(8)
                                                           : bytes_left_ff[ctd_pkg::VB_W-1:0];
   assign last_word = (bytes_left_ff <= ctd_pkg::LEN_W'(8));

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      packet_seen_in = packet_seen_ff;
      case (phase_ff)
         ctd_pkg::PH_META: begin
            if (accept) begin
               if (is_end) begin
                  phase_in = ctd_pkg::PH_DONE;
               end else begin
                  packet_seen_in = 1'b1;
                  bytes_left_in  = cap_len;
                  phase_in       = (cap_len == '0) ? ctd_pkg::PH_META : ctd_pkg::PH_DATA;
               end
            end
         end
         ctd_pkg::PH_DATA: begin
            if (accept) begin
               bytes_left_in = bytes_left_ff - ctd_pkg::LEN_W'(take);
               if (last_word) begin
                  phase_in = ctd_pkg::PH_META;
               end
            end
         end
         ctd_pkg::PH_DONE: begin
            phase_in = ctd_pkg::PH_DONE;
         end
         default: begin
            phase_in = ctd_pkg::PH_META;
         end
      endcase
   end

   // Outputs
   always_comb begin
      queue_push  = 1'b0;
      queue_entry = '0;
      case (phase_ff)
         ctd_pkg::PH_META: begin
            queue_push = accept;
            if (is_end) begin
               queue_entry.kind = ctd_pkg::KIND_END;
               queue_entry.last = 1'b1;
            end else begin
               queue_entry.kind           = ctd_pkg::KIND_HEADER;
               queue_entry.capture_length = cap_len;
               queue_entry.wire_length    = wire_len;
               queue_entry.six_cycles     = six;
               queue_entry.fifth_cycles   = prod[ctd_pkg::PROD_W-1 -: ctd_pkg::FIFTH_W];
               queue_entry.last           = (cap_len == '0);
            end
         end
         ctd_pkg::PH_DATA: begin
            queue_push              = accept;
            queue_entry.kind        = ctd_pkg::KIND_DATA;
            queue_entry.data_word   = req_trace_word & keep_mask(take);
            queue_entry.valid_bytes = take;
            queue_entry.last        = last_word;
         end
         default: begin
            queue_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ctd_pkg::PH_META;
         bytes_left_ff  <= '0;
         packet_seen_ff <= 1'b0;
         max_cap_ff     <= ctd_pkg::MAX_CAP_RESET;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         packet_seen_ff <= packet_seen_in;
         if (csr_write_enable) begin
            max_cap_ff <= csr_write_data;
         end
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == ctd_pkg::PH_DATA) |-> (bytes_left_ff != '0))
      else $error("data phase with no bytes left");

endmodule

// File: design/ctd_back.sv
`timescale 1ns / 1ps
// Back end: forms the timestamp delta, keeps the running clock and holds the result.
// Depends on ctd_pkg; reads from ctd_fifo.
module ctd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          queue_empty,
   input  ctd_pkg::entry_type            queue_entry,
   output logic                          queue_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ctd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [ctd_pkg::LEN_W-1:0]     rsp_capture_length,
   output logic [ctd_pkg::LEN_W-1:0]     rsp_wire_length,
   output logic [ctd_pkg::SEC_W-1:0]     rsp_stamp_seconds,
   output logic [ctd_pkg::NS_W-1:0]      rsp_stamp_nanoseconds,
   output logic [ctd_pkg::TRACE_W-1:0]   rsp_data_word,
   output logic [ctd_pkg::VB_W-1:0]      rsp_valid_bytes,
   output logic                          rsp_last
);

   // Delta stage
   logic                          p_valid_ff, p_valid_in;
   ctd_pkg::entry_type            p_entry_ff;
   logic [ctd_pkg::SIX_W-1:0]     p_d0_ff, p_d0_in;
   logic [ctd_pkg::DELTA_W-1:0]   p_d1_ff, p_d1_in;
   logic [ctd_pkg::DELTA_W-1:0]   p_d2_ff, p_d2_in;

   // Running clock
   logic [ctd_pkg::SEC_W-1:0]     sec_ff, sec_in;
   logic [ctd_pkg::NS_W-1:0]      ns_ff, ns_in;

   // Result register
   logic                          out_valid_ff, out_valid_in;
   ctd_pkg::kind_type             out_kind_ff;
   logic [ctd_pkg::LEN_W-1:0]     out_cap_ff, out_wire_ff;
   logic [ctd_pkg::SEC_W-1:0]     out_sec_ff;
   logic [ctd_pkg::NS_W-1:0]      out_ns_ff;
   logic [ctd_pkg::TRACE_W-1:0]   out_data_ff;
   logic [ctd_pkg::VB_W-1:0]      out_vb_ff;
   logic                          out_last_ff;

   logic                          out_load;
   logic                          is_header;
   logic [ctd_pkg::DELTA_W-1:0]   s0;
   logic [ctd_pkg::DELTA_W:0]     s1, s2;
   logic [ctd_pkg::SEC_W-1:0]     stamp_sec;
   logic [ctd_pkg::NS_W-1:0]      stamp_ns;

   assign out_load  = p_valid_ff && (!out_valid_ff || rsp_ready);
   assign queue_pop = !queue_empty && (!p_valid_ff || out_load);

   assign p_valid_in   = queue_pop || (p_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   // Delta (31-bit unsigned) and two carry-corrected variants (32-bit two's complement).
   assign p_d0_in = queue_entry.six_cycles + ctd_pkg::SIX_W'(queue_entry.fifth_cycles);
   assign p_d1_in = ctd_pkg::DELTA_W'(queue_entry.six_cycles)
                  + ctd_pkg::DELTA_W'(queue_entry.fifth_cycles) - ctd_pkg::NS_PER_SEC;
   assign p_d2_in = ctd_pkg::DELTA_W'(queue_entry.six_cycles)
                  + ctd_pkg::DELTA_W'(queue_entry.fifth_cycles) - ctd_pkg::NS_PER_TWO_SEC;

   assign is_header = (p_entry_ff.kind == ctd_pkg::KIND_HEADER);
   assign s0 = ctd_pkg::DELTA_W'(ns_ff) + ctd_pkg::DELTA_W'(p_d0_ff);
   assign s1 = (ctd_pkg::DELTA_W+1)'(ns_ff) + {p_d1_ff[ctd_pkg::DELTA_W-1], p_d1_ff};
   assign s2 = (ctd_pkg::DELTA_W+1)'(ns_ff) + {p_d2_ff[ctd_pkg::DELTA_W-1], p_d2_ff};

   always_comb begin
      if (!s2[ctd_pkg::DELTA_W]) begin
         stamp_ns  = s2[ctd_pkg::NS_W-1:0];
         stamp_sec = sec_ff + ctd_pkg::SEC_W'(2);
      end else if (!s1[ctd_pkg::DELTA_W]) begin
         stamp_ns  = s1[ctd_pkg::NS_W-1:0];
         stamp_sec = sec_ff + ctd_pkg::SEC_W'(1);
      end else begin
         stamp_ns  = s0[ctd_pkg::NS_W-1:0];
         stamp_sec = sec_ff;
      end
   end

   assign sec_in = (out_load && is_header) ? stamp_sec : sec_ff;
   assign ns_in  = (out_load && is_header) ? stamp_ns  : ns_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_ff       <= '0;
         ns_ff        <= '0;
      end else begin
         p_valid_ff   <= p_valid_in;
         out_valid_ff <= out_valid_in;
         sec_ff       <= sec_in;
         ns_ff        <= ns_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         p_entry_ff <= queue_entry;
         p_d0_ff    <= p_d0_in;
         p_d1_ff    <= p_d1_in;
         p_d2_ff    <= p_d2_in;
      end
      if (out_load) begin
         out_kind_ff <= p_entry_ff.kind;
         out_cap_ff  <= p_entry_ff.capture_length;
         out_wire_ff <= p_entry_ff.wire_length;
         out_sec_ff  <= is_header ? stamp_sec : '0;
         out_ns_ff   <= is_header ? stamp_ns  : '0;
         out_data_ff <= p_entry_ff.data_word;
         out_vb_ff   <= p_entry_ff.valid_bytes;
         out_last_ff <= p_entry_ff.last;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_kind              = out_kind_ff;
   assign rsp_capture_length    = out_cap_ff;
   assign rsp_wire_length       = out_wire_ff;
   assign rsp_stamp_seconds     = out_sec_ff;
   assign rsp_stamp_nanoseconds = out_ns_ff;
   assign rsp_data_word         = out_data_ff;
   assign rsp_valid_bytes       = out_vb_ff;
   assign rsp_last              = out_last_ff;

   a_ns_in_range: assert property (@(posedge clock) disable iff (reset)
      ns_ff < ctd_pkg::NS_W'(ctd_pkg::NS_PER_SEC))
      else $error("running nanoseconds out of range");

   a_data_bytes: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == ctd_pkg::KIND_DATA)
         |-> (out_vb_ff != '0 && out_vb_ff <= ctd_pkg::VB_W'(8)))
      else $error("data result with bad byte count");

endmodule

// File: design/capture_trace_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the capture trace deframer: front end, item queue and back end.
// Depends on ctd_pkg, ctd_front, ctd_fifo and ctd_back.
//
// The deframer takes a capture trace one 64-bit word per transfer, byte 0 in the
// low bits, and gives one result per meaningful word. A meta word carries the
// wire length in bits 63..53 and the clock-cycle gap to the previous packet in
// bits 52..25; it yields a header result with the capture length (the wire
// length clamped to the max_capture_length register), the wire length and a
// running timestamp. The first packet after reset is stamped zero; each later
// one adds floor(gap * 32 / 5) ns (6.4 ns per 156.25 MHz cycle), carrying into
// seconds at one billion. The header is followed by ceil(capture_length / 8)
// data results, each with its valid-byte count, bytes above that count zeroed,
// and the last one flagged. A header with zero capture length is itself the
// last result of its packet. A meta word of all ones gives an end-of-trace
// result, after which every word is taken and dropped until reset. The block
// takes one word per clock and delivers one result per clock when the consumer
// keeps rsp_ready high: a front end classifies each word in the cycle it
// arrives, a short queue decouples it from the back end, and the back end
// forms the timestamp delta as it takes an item from the queue and adds it to
// the running clock as it loads the result register. A word's result is
// therefore presented only once it has passed through the queue entry, the
// delta stage and the result register. The throughput is set by the
// running-clock update, which handles one header per cycle while the result
// register can load. Write the max_capture_length register only while the
// block is idle; a new value takes effect from the next meta word.
module capture_trace_deframer_top #(
   parameter int QueueDepth = ctd_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ctd_pkg::TRACE_W-1:0]   req_trace_word,
   input  logic                          csr_write_enable,
   input  logic [ctd_pkg::LEN_W-1:0]     csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ctd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [ctd_pkg::LEN_W-1:0]     rsp_capture_length,
   output logic [ctd_pkg::LEN_W-1:0]     rsp_wire_length,
   output logic [ctd_pkg::SEC_W-1:0]     rsp_stamp_seconds,
   output logic [ctd_pkg::NS_W-1:0]      rsp_stamp_nanoseconds,
   output logic [ctd_pkg::TRACE_W-1:0]   rsp_data_word,
   output logic [ctd_pkg::VB_W-1:0]      rsp_valid_bytes,
   output logic                          rsp_last
);

   // Classified items pass from the front end to the back end through the queue.
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   ctd_pkg::entry_type q_wr_entry;
   ctd_pkg::entry_type q_rd_entry;

   // The front end owns the framing state and the capture-length register.
   ctd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_trace_word   (req_trace_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (q_full),
      .queue_push       (q_push),
      .queue_entry      (q_wr_entry)
   );

   ctd_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_wr_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_rd_entry),
      .empty      (q_empty)
   );

   // The back end owns the running timestamp and the result register.
   ctd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .queue_empty           (q_empty),
      .queue_entry           (q_rd_entry),
      .queue_pop             (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_capture_length    (rsp_capture_length),
      .rsp_wire_length       (rsp_wire_length),
      .rsp_stamp_seconds     (rsp_stamp_seconds),
      .rsp_stamp_nanoseconds (rsp_stamp_nanoseconds),
      .rsp_data_word         (rsp_data_word),
      .rsp_valid_bytes       (rsp_valid_bytes),
      .rsp_last              (rsp_last)
   );

endmodule
